FILE: rtl/bcdtd_pkg.sv
// Package for the BCD time and date field setter.
// Holds the item, result and state types and the field, action and address codes.
// Depends on nothing.
package bcdtd_pkg;

  localparam logic       MODE_LOAD   = 1'b0;
  localparam logic       MODE_ADJUST = 1'b1;

  localparam logic [1:0] ACT_DEC   = 2'd0;
  localparam logic [1:0] ACT_INC   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] FIELD_WEEKDAY = 3'd0;
  localparam logic [2:0] FIELD_HOUR    = 3'd1;
  localparam logic [2:0] FIELD_MINUTE  = 3'd2;
  localparam logic [2:0] FIELD_YEAR    = 3'd3;
  localparam logic [2:0] FIELD_MONTH   = 3'd4;
  localparam logic [2:0] FIELD_DAY     = 3'd5;

  localparam logic [2:0] ADDR_SEC     = 3'd0;
  localparam logic [2:0] ADDR_MIN     = 3'd1;
  localparam logic [2:0] ADDR_HOUR    = 3'd2;
  localparam logic [2:0] ADDR_WEEKDAY = 3'd3;
  localparam logic [2:0] ADDR_DAY     = 3'd4;
  localparam logic [2:0] ADDR_MONTH   = 3'd5;
  localparam logic [2:0] ADDR_YEAR    = 3'd6;

  typedef struct packed {
    logic       mode;
    logic [2:0] field_select;
    logic [1:0] action;
    logic [7:0] raw_seconds;
    logic [7:0] raw_minutes;
    logic [7:0] raw_hours;
    logic [7:0] raw_weekday;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
  } item_t;

  typedef struct packed {
    logic       write_valid;
    logic [2:0] reg_address;
    logic [7:0] reg_value;
  } result_t;

  typedef struct packed {
    logic [7:0] second_digits;
    logic [7:0] minute_digits;
    logic [5:0] hour_digits;
    logic [3:0] weekday_number;
    logic [7:0] day_digits;
    logic [7:0] month_digits;
    logic [7:0] year_digits;
  } time_state_t;

endpackage

FILE: rtl/bcd_time_date_field_setter_top.sv
// Top level of the BCD time and date field setter: input register, step unit, result register.
// Depends on bcdtd_pkg and bcdtd_step.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------------
//   input   | in_valid / in_ready | mode, field_select, action, raw_seconds..raw_year
//   output  | out_valid/out_ready | write_valid, reg_address, reg_value
//
// One result per item. An item passes the input register and then the result register, which
// drives the output channel.
// Sustained rate is one item per cycle while out_ready stays high; the time state updates as
// an item leaves the input register, so the next item sees it at once.
// Reset clears the time state and both valid flags.
// A stalled output holds the result and the input register; in_ready drops only then.
module bcd_time_date_field_setter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [2:0] field_select,
  input  logic [1:0] action,
  input  logic [7:0] raw_seconds,
  input  logic [7:0] raw_minutes,
  input  logic [7:0] raw_hours,
  input  logic [7:0] raw_weekday,
  input  logic [7:0] raw_day,
  input  logic [7:0] raw_month,
  input  logic [7:0] raw_year,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       write_valid,
  output logic [2:0] reg_address,
  output logic [7:0] reg_value
);

  logic                   s1_valid;
  bcdtd_pkg::item_t       s1_item;
  bcdtd_pkg::time_state_t state;
  bcdtd_pkg::time_state_t state_next;
  bcdtd_pkg::result_t     res_next;
  bcdtd_pkg::result_t     out_res;
  logic                   advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  bcdtd_step u_step (
    .item (s1_item),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{mode: mode, field_select: field_select, action: action,
                   raw_seconds: raw_seconds, raw_minutes: raw_minutes,
                   raw_hours: raw_hours, raw_weekday: raw_weekday, raw_day: raw_day,
                   raw_month: raw_month, raw_year: raw_year};
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign write_valid = out_res.write_valid;
  assign reg_address = out_res.reg_address;
  assign reg_value   = out_res.reg_value;

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register lost or changed a waiting item");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item produced no result");

  a_clear_sec: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.mode == bcdtd_pkg::MODE_ADJUST &&
    s1_item.action == bcdtd_pkg::ACT_CLEAR |=> state.second_digits == 8'h00)
    else $error("clear left seconds nonzero");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> reg_address == bcdtd_pkg::ADDR_SEC && reg_value == 8'h00)
    else $error("result without write carries data");

  a_hour_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid && reg_address == bcdtd_pkg::ADDR_HOUR |-> reg_value[7:6] == 2'b00)
    else $error("hour write exceeds six bits");

endmodule

FILE: rtl/bcdtd_step.sv
// Combinational step unit: applies one load, adjust or clear item to the time state.
// Produces the next state and the clock register write, if any, for the item.
// Depends on bcdtd_pkg.
module bcdtd_step (
  input  bcdtd_pkg::item_t       item,
  input  bcdtd_pkg::time_state_t cur,
  output bcdtd_pkg::time_state_t nxt,
  output bcdtd_pkg::result_t     res
);

  localparam logic [4:0] DAYS_31 = 5'd31;
  localparam logic [4:0] DAYS_30 = 5'd30;
  localparam logic [4:0] DAYS_29 = 5'd29;
  localparam logic [4:0] DAYS_28 = 5'd28;

  function automatic logic [7:0] bcd_value(input logic [3:0] t, input logic [3:0] o);
    return {1'b0, t, 3'b000} + {3'b000, t, 1'b0} + {4'h0, o};
  endfunction

  function automatic logic [7:0] step_plain(input logic [7:0] v, input logic up,
                                            input logic [3:0] top);
    logic [3:0] t;
    logic [3:0] o;
    t = v[7:4];
    o = v[3:0];
    if (up) begin
      if (o < 4'd9) begin
        o = o + 4'd1;
      end else begin
        o = 4'd0;
        t = (t < top) ? t + 4'd1 : 4'd0;
      end
    end else begin
      if (o > 4'd0) begin
        o = o - 4'd1;
      end else begin
        o = 4'd9;
        t = (t > 4'd0) ? t - 4'd1 : top;
      end
    end
    return {t, o};
  endfunction

  function automatic logic [5:0] step_hour(input logic [5:0] v, input logic up);
    logic [1:0] t;
    logic [3:0] o;
    t = v[5:4];
    o = v[3:0];
    if (up) begin
      if (t == 2'd2 && o == 4'd3) begin
        t = 2'd0;
        o = 4'd0;
      end else if (o < 4'd9) begin
        o = o + 4'd1;
      end else begin
        o = 4'd0;
        t = t + 2'd1;
      end
    end else begin
      if (o > 4'd0) begin
        o = o - 4'd1;
      end else if (t > 2'd0) begin
        o = 4'd9;
        t = t - 2'd1;
      end else begin
        t = 2'd2;
        o = 4'd3;
      end
    end
    return {t, o};
  endfunction

  function automatic logic [7:0] step_month(input logic [7:0] v, input logic up);
    logic [3:0] t;
    logic [3:0] o;
    t = v[7:4];
    o = v[3:0];
    if (up) begin
      if (t == 4'd1 && o >= 4'd2) begin
        t = 4'd0;
        o = 4'd1;
      end else if (o < 4'd9) begin
        o = o + 4'd1;
      end else begin
        o = 4'd0;
        t = t + 4'd1;
      end
    end else begin
      if (t == 4'd0 && o <= 4'd1) begin
        t = 4'd1;
        o = 4'd2;
      end else if (o > 4'd0) begin
        o = o - 4'd1;
      end else begin
        o = 4'd9;
        t = t - 4'd1;
      end
    end
    return {t, o};
  endfunction

  function automatic logic [7:0] step_day(input logic [7:0] v, input logic up,
                                          input logic [4:0] len);
    logic [3:0] t;
    logic [3:0] o;
    logic [4:0] rem;
    t = v[7:4];
    o = v[3:0];
    rem = '0;
    if (up) begin
      if (bcd_value(t, o) >= {3'b000, len}) begin
        t = 4'd0;
        o = 4'd1;
      end else if (o < 4'd9) begin
        o = o + 4'd1;
      end else begin
        o = 4'd0;
        t = t + 4'd1;
      end
    end else begin
      if (t == 4'd0 && o <= 4'd1) begin
        if (len >= DAYS_30) begin
          t = 4'd3;
          rem = len - 5'd30;
        end else begin
          t = 4'd2;
          rem = len - 5'd20;
        end
        o = rem[3:0];
      end else if (o > 4'd0) begin
        o = o - 4'd1;
      end else begin
        o = 4'd9;
        t = t - 4'd1;
      end
    end
    return {t, o};
  endfunction

  logic [7:0] month_num;
  logic [7:0] year_num;
  logic       leap;
  logic [4:0] month_len;
  logic       up;

  always_comb begin
    month_num = bcd_value(cur.month_digits[7:4], cur.month_digits[3:0]);
    year_num  = bcd_value(cur.year_digits[7:4], cur.year_digits[3:0]);
    leap      = (year_num[1:0] == 2'd0) && (year_num != 8'd100);
    case (month_num) inside
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: month_len = DAYS_31;
      8'd2:    month_len = leap ? DAYS_29 : DAYS_28;
      default: month_len = DAYS_30;
    endcase
  end

  always_comb begin
    nxt = cur;
    res = '0;
    up  = (item.action == bcdtd_pkg::ACT_INC);
    if (item.mode == bcdtd_pkg::MODE_LOAD) begin
      nxt.second_digits  = item.raw_seconds;
      nxt.minute_digits  = item.raw_minutes;
      nxt.hour_digits    = item.raw_hours[5:0];
      nxt.weekday_number = item.raw_weekday[3:0];
      nxt.day_digits     = item.raw_day;
      nxt.month_digits   = item.raw_month;
      nxt.year_digits    = item.raw_year;
    end else if (item.action == bcdtd_pkg::ACT_CLEAR) begin
      nxt.second_digits = '0;
      res.write_valid   = 1'b1;
      res.reg_address   = bcdtd_pkg::ADDR_SEC;
    end else if (item.action == bcdtd_pkg::ACT_DEC || item.action == bcdtd_pkg::ACT_INC) begin
      case (item.field_select)
        bcdtd_pkg::FIELD_WEEKDAY: begin
          if (up) begin
            nxt.weekday_number = (cur.weekday_number < 4'd7) ? cur.weekday_number + 4'd1
                                                             : 4'd1;
          end else begin
            nxt.weekday_number = (cur.weekday_number > 4'd1) ? cur.weekday_number - 4'd1
                                                             : 4'd7;
          end
          res.write_valid = 1'b1;
          res.reg_address = bcdtd_pkg::ADDR_WEEKDAY;
          res.reg_value   = {4'h0, nxt.weekday_number};
        end
        bcdtd_pkg::FIELD_HOUR: begin
          nxt.hour_digits = step_hour(cur.hour_digits, up);
          res.write_valid = 1'b1;
          res.reg_address = bcdtd_pkg::ADDR_HOUR;
          res.reg_value   = {2'b00, nxt.hour_digits};
        end
        bcdtd_pkg::FIELD_MINUTE: begin
          nxt.minute_digits = step_plain(cur.minute_digits, up, 4'd5);
          res.write_valid   = 1'b1;
          res.reg_address   = bcdtd_pkg::ADDR_MIN;
          res.reg_value     = nxt.minute_digits;
        end
        bcdtd_pkg::FIELD_YEAR: begin
          nxt.year_digits = step_plain(cur.year_digits, up, 4'd9);
          res.write_valid = 1'b1;
          res.reg_address = bcdtd_pkg::ADDR_YEAR;
          res.reg_value   = nxt.year_digits;
        end
        bcdtd_pkg::FIELD_MONTH: begin
          nxt.month_digits = step_month(cur.month_digits, up);
          res.write_valid  = 1'b1;
          res.reg_address  = bcdtd_pkg::ADDR_MONTH;
          res.reg_value    = nxt.month_digits;
        end
        bcdtd_pkg::FIELD_DAY: begin
          nxt.day_digits  = step_day(cur.day_digits, up, month_len);
          res.write_valid = 1'b1;
          res.reg_address = bcdtd_pkg::ADDR_DAY;
          res.reg_value   = nxt.day_digits;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule
